### design/lpe_pkg.sv
// Shared types, constants and code helpers for the lossless plane encoder.
package lpe_pkg;

  localparam int NUM_CONTEXTS = 128;
  localparam int CTX_W        = 7;
  localparam int AVG_W        = 24;
  localparam logic [AVG_W-1:0] AVG_INIT = 24'h030000;  // 3.0 in 8.16
  localparam int ESC_Q        = 24;
  localparam logic [3:0] RUN_K = 4'd3;
  localparam int CODE_W       = 43;
  localparam int LEN_W        = 6;

  typedef logic signed [8:0] resid_t;

  typedef struct packed {
    resid_t           res;
    logic [CTX_W-1:0] ctx;
    logic             eop;
  } lpe_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } code_t;

  // k = round(log2 A) (1 in [0.5,1), 0 below): thresholds ceil(2^(j+15.5)); j above 8 is past 24 bits
  function automatic logic [3:0] k_of(input logic [AVG_W-1:0] avg);
    logic [3:0] k;
    k = 4'd0;
    if (avg < 24'h008000) begin
      k = 4'd0;
    end else if (avg < 24'h010000) begin
      k = 4'd1;
    end else begin
      if (avg >= 24'd92682)    k = 4'd1;
      if (avg >= 24'd185364)   k = 4'd2;
      if (avg >= 24'd370728)   k = 4'd3;
      if (avg >= 24'd741456)   k = 4'd4;
      if (avg >= 24'd1482911)  k = 4'd5;
      if (avg >= 24'd2965821)  k = 4'd6;
      if (avg >= 24'd5931642)  k = 4'd7;
      if (avg >= 24'd11863284) k = 4'd8;
    end
    return k;
  endfunction

  // flag, unary quotient, stop bit, k low bits; escape when the quotient is too long
  function automatic code_t make_code(input logic flag, input logic [15:0] v,
                                      input logic [3:0] k);
    logic [15:0] q;
    logic [5:0]  sh;
    logic [42:0] ones;
    code_t       c;
    q = v >> k;
    sh = {1'b0, q[4:0]} + {2'b00, k} + 6'd1;
    ones = (43'd1 << q[4:0]) - 43'd1;
    if (q > 16'(ESC_Q)) begin
      c.bits = {flag, 25'h1FFFFFF, 1'b0, v};
      c.len  = 6'd43;
    end else begin
      c.bits = ({42'd0, flag} << sh) | (ones << ({2'b00, k} + 6'd1))
             | ({27'd0, v} & ((43'd1 << k) - 43'd1));
      c.len  = {1'b0, q[4:0]} + {2'b00, k} + 6'd2;
    end
    return c;
  endfunction

endpackage

### design/lpe_front.sv
// Front end: pixel intake, row memory, median prediction and context classification.
module lpe_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [12:0]       cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        pixel,
  input  logic              end_of_plane,
  output logic              out_valid,
  input  logic              out_ready,
  output lpe_pkg::lpe_item_t out_item
);
  import lpe_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);

  logic [12:0]   image_width;
  logic [CW-1:0] w_eff;
  logic [AW-1:0] column_index;
  logic [AW-1:0] col;
  logic [AW-1:0] col_p1;
  logic          first_row;
  logic          last_col;
  logic          accept;

  logic [7:0] row_mem [MAX_WIDTH];
  logic [7:0] rd0;
  logic [7:0] rd1;

  logic       s1_valid;
  logic [7:0] s1_pix;
  logic       s1_col0;
  logic       s1_last;
  logic       s1_first;
  logic       s1_eop;
  logic [7:0] prev_pix;
  logic [7:0] prev_b;

  logic [7:0] a, b, c, d, lo, hi, pred;
  logic signed [9:0] diff, gh, gv, gd;
  logic [8:0] ah, av, ad;
  logic [9:0] g;
  logic [2:0] lvl;
  logic [1:0] dir;
  resid_t     res;

  always_comb begin
    if (image_width == 13'd0) begin
      w_eff = CW'(1);
    end else if ({19'd0, image_width} > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(image_width);
    end
  end

  // a column past a lowered width starts a new row
  assign col      = (CW'(column_index) >= w_eff) ? '0 : column_index;
  assign col_p1   = col + AW'(1);
  assign last_col = (CW'(col) + CW'(1)) >= w_eff;
  assign in_ready = !s1_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd4096;
      column_index <= '0;
      first_row    <= 1'b1;
      s1_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) image_width <= cfg_wr_data;
      if (accept) begin
        if (end_of_plane) begin
          column_index <= '0;
          first_row    <= 1'b1;
        end else if (last_col) begin
          column_index <= '0;
          first_row    <= 1'b0;
        end else begin
          column_index <= col_p1;
        end
        s1_valid <= 1'b1;
      end else if (out_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // read-before-write: the reads return the previous row
  always_ff @(posedge clk) begin
    if (accept) begin
      row_mem[col] <= pixel;
      rd0          <= row_mem[col];
      rd1          <= row_mem[col_p1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pixel;
      s1_col0  <= (col == '0);
      s1_last  <= last_col;
      s1_first <= first_row;
      s1_eop   <= end_of_plane;
    end
    if (s1_valid && out_ready) begin
      prev_pix <= s1_pix;
      prev_b   <= b;
    end
  end

  always_comb begin
    a = s1_col0 ? 8'd0 : prev_pix;
    b = s1_first ? 8'd0 : rd0;
    c = (!s1_col0 && !s1_first) ? prev_b : 8'd0;
    d = (!s1_first && !s1_last) ? rd1 : b;

    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c >= hi) begin
      pred = lo;
    end else if (c <= lo) begin
      pred = hi;
    end else begin
      pred = 8'(({1'b0, a} + {1'b0, b}) - {1'b0, c});
    end

    diff = signed'({2'b00, s1_pix}) - signed'({2'b00, pred});
    if (diff > 10'sd128) begin
      res = 9'(diff - 10'sd256);
    end else if (diff < -10'sd128) begin
      res = 9'(diff + 10'sd256);
    end else begin
      res = 9'(diff);
    end

    gh = signed'({2'b00, a}) - signed'({2'b00, c});
    gv = signed'({2'b00, b}) - signed'({2'b00, c});
    gd = signed'({2'b00, d}) - signed'({2'b00, b});
    ah = gh[9] ? 9'(-gh) : 9'(gh);
    av = gv[9] ? 9'(-gv) : 9'(gv);
    ad = gd[9] ? 9'(-gd) : 9'(gd);
    g  = {1'b0, ah} + {1'b0, av} + {1'b0, ad};

    priority if (g < 10'd3)   lvl = 3'd0;
    else if (g < 10'd8)       lvl = 3'd1;
    else if (g < 10'd16)      lvl = 3'd2;
    else if (g < 10'd30)      lvl = 3'd3;
    else if (g < 10'd50)      lvl = 3'd4;
    else if (g < 10'd80)      lvl = 3'd5;
    else if (g < 10'd130)     lvl = 3'd6;
    else                      lvl = 3'd7;

    priority if (ah < 9'd3 && av < 9'd3)   dir = 2'd0;
    else if ({1'b0, ah} > {av, 1'b0})      dir = 2'd1;
    else if ({1'b0, av} > {ah, 1'b0})      dir = 2'd2;
    else                                   dir = 2'd3;
  end

  assign out_valid    = s1_valid;
  assign out_item.res = res;
  assign out_item.ctx = {lvl, dir, gv[9], gh[9]};
  assign out_item.eop = s1_eop;

endmodule

### design/lpe_queue.sv
// Short queue between the classifying front end and the coding back end.
module lpe_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpe_pkg::lpe_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output lpe_pkg::lpe_item_t out_item
);
  import lpe_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  lpe_item_t     slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != (PW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop)      count <= count + (PW+1)'(1);
      else if (pop && !push) count <= count - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

endmodule

### design/lpe_back.sv
// Back end: run tracking, context averages, Rice codes and the output register.
module lpe_back #(
  parameter int MAX_RUN = 32768
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lpe_pkg::lpe_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [42:0]        code_bits,
  output logic [5:0]         code_length,
  output logic               last_of_item
);
  import lpe_pkg::*;

  logic [AVG_W-1:0]        avg_mem [NUM_CONTEXTS];
  logic [NUM_CONTEXTS-1:0] avg_vld;
  logic [AVG_W-1:0]        avg_rd;
  logic [AVG_W-1:0]        avg_fwd;
  logic                    use_init;
  logic                    use_fwd;

  logic      b_valid;
  lpe_item_t b_item;
  logic      phase;       // run code of a two-code item already sent
  logic [15:0] zero_run;

  logic [AVG_W-1:0] avg;
  logic [AVG_W-1:0] avg_new;
  logic [26:0]      avg_x7;
  logic        res_zero;
  logic [15:0] run_inc;
  logic        flush;
  logic [7:0]  mag;
  logic [8:0]  zz;
  logic [3:0]  k;
  logic [15:0] run_m1;
  code_t       run_code;
  code_t       res_code;
  logic        two;
  logic        none;
  logic        out_free;
  logic        emit;
  logic        commit;
  logic        load;
  logic        sel_run;
  logic        fwd_hit;

  always_comb begin
    avg      = use_init ? AVG_INIT : (use_fwd ? avg_fwd : avg_rd);
    res_zero = (b_item.res == '0);
    run_inc  = zero_run + 16'd1;
    flush    = ({1'b0, run_inc} >= 17'(MAX_RUN)) || b_item.eop;
    mag      = b_item.res[8] ? 8'(-b_item.res) : 8'(b_item.res);
    zz       = b_item.res[8] ? ({mag, 1'b0} - 9'd1) : {mag, 1'b0};
    k        = k_of(avg);
    run_m1   = res_zero ? zero_run : (zero_run - 16'd1);
    run_code = make_code(1'b1, {run_m1[14:0], 1'b0}, RUN_K);
    res_code = make_code(1'b0, {7'd0, zz}, k);
    avg_x7   = {avg, 3'b000} - {3'b000, avg};
    avg_new  = avg_x7[26:3] + {3'b000, mag, 13'd0};

    two      = !res_zero && (zero_run != 16'd0);
    none     = res_zero && !flush;
    out_free = !out_valid || out_ready;
    emit     = b_valid && !none && out_free;
    commit   = b_valid && (none || (out_free && (!two || phase)));
    load     = in_valid && (!b_valid || commit);
    sel_run  = res_zero || (two && !phase);
    fwd_hit  = commit && !res_zero && (b_item.ctx == in_item.ctx);
  end

  assign in_ready = !b_valid || commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      phase     <= 1'b0;
      zero_run  <= '0;
      avg_vld   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load)        b_valid <= 1'b1;
      else if (commit) b_valid <= 1'b0;

      if (commit)    phase <= 1'b0;
      else if (emit) phase <= 1'b1;

      if (commit) begin
        if (b_item.eop || !res_zero || flush) zero_run <= '0;
        else                                  zero_run <= run_inc;
        if (b_item.eop)     avg_vld <= '0;
        else if (!res_zero) avg_vld[b_item.ctx] <= 1'b1;
      end

      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // average read at entry, with the update of the item leaving in the same cycle forwarded
  always_ff @(posedge clk) begin
    if (commit && !res_zero) avg_mem[b_item.ctx] <= avg_new;
    if (load) begin
      b_item   <= in_item;
      avg_rd   <= avg_mem[in_item.ctx];
      avg_fwd  <= avg_new;
      use_fwd  <= fwd_hit;
      use_init <= (commit && b_item.eop) || (!fwd_hit && !avg_vld[in_item.ctx]);
    end
    if (emit) begin
      code_bits    <= sel_run ? run_code.bits : res_code.bits;
      code_length  <= sel_run ? run_code.len : res_code.len;
      last_of_item <= !(two && !phase);
    end
  end

endmodule

### design/lossless_plane_encoder_top.sv
// Top level of the lossless plane encoder: front end, queue and back end.
// Throughput: one pixel per cycle while m_axis_tready stays high; a pixel that closes a run
// and has a nonzero residual sends two codewords in turn, as the output register carries
// one codeword a cycle.
// Reset (rst, synchronous): width 4096, first row, empty run, all averages 3.0;
// the row memory holds no reset value and needs no clearing pass.
module lossless_plane_encoder_top #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_RUN   = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,    // image_width
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tlast,   // end_of_plane
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [42:0] code_bits, [48:43] code_length, rest zero
  output logic        m_axis_tlast    // last_of_item
);
  import lpe_pkg::*;

  logic      fq_valid;
  logic      fq_ready;
  lpe_item_t fq_item;
  logic      qb_valid;
  logic      qb_ready;
  lpe_item_t qb_item;
  logic [42:0] out_bits;
  logic [5:0]  out_len;

  lpe_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .pixel        (s_axis_tdata),
    .end_of_plane (s_axis_tlast),
    .out_valid    (fq_valid),
    .out_ready    (fq_ready),
    .out_item     (fq_item)
  );

  lpe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_item   (fq_item),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_item  (qb_item)
  );

  lpe_back #(.MAX_RUN(MAX_RUN)) u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (qb_valid),
    .in_ready     (qb_ready),
    .in_item      (qb_item),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .code_bits    (out_bits),
    .code_length  (out_len),
    .last_of_item (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_len, out_bits};

  a_len_range : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_len >= 6'd3 && out_len <= 6'd43))
    else $error("codeword length out of range");

  a_no_stray_bits : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((out_bits >> out_len) == 43'd0))
    else $error("codeword has bits above its length");

  // a codeword that is not the last of its pixel is always a run code
  a_run_first : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (((out_bits >> (out_len - 6'd1)) & 43'd1) == 43'd1))
    else $error("leading codeword of a pixel is not a run code");

endmodule
